@@ rtl/ccterm_pkg.sv @@
// shared types and constants for the character-cell terminal controller
package ccterm_pkg;

    typedef enum logic [2:0] {
        CMD_CURSOR = 3'd0,
        CMD_DRAW   = 3'd1,
        CMD_BELL   = 3'd2,
        CMD_VBELL  = 3'd3,
        CMD_MOVE   = 3'd4,
        CMD_EOL    = 3'd5,
        CMD_CLEAR  = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_COL  = 2'd2,
        PH_ROW  = 2'd3
    } phase_t;

    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_UP  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_Y   = 8'h59;
    localparam logic [7:0] CH_I   = 8'h49;
    localparam logic [7:0] CH_D   = 8'h44;
    localparam logic [7:0] CH_K   = 8'h4B;

    localparam logic [7:0] REG_MAX = 8'd254;

    localparam logic [1:0] REG_LAST_COLUMN = 2'd0;
    localparam logic [1:0] REG_LAST_ROW    = 2'd1;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        phase_t     phase;
        logic [7:0] pending;
    } term_state_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] glyph;
        logic [7:0] target_col;
        logic [7:0] target_row;
        logic [7:0] source_first_row;
        logic [7:0] source_end_row;
        logic [7:0] dest_first_row;
        logic [7:0] blank_row;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
        logic       last;
    } result_t;

endpackage

@@ rtl/ccterm_decode.sv @@
// byte decoder: cursor update, escape parsing and command generation
module ccterm_decode
    import ccterm_pkg::*;
(
    input  logic [7:0]  rx_byte,
    input  term_state_t state,
    input  logic [7:0]  last_column,
    input  logic [7:0]  last_row,
    output term_state_t state_next,
    output result_t     first,
    output result_t     second,
    output logic        two
);

    logic [8:0]  x;
    logic [7:0]  y;
    logic        done;
    logic        have_main;
    logic        wrap_scroll;
    result_t     main_res;
    result_t     scroll_res;
    logic [7:0]  clamp_col;
    logic [7:0]  clamp_row;
    logic [8:0]  tab_col;

    always_comb
    begin
        x           = {1'b0, state.col};
        y           = state.row;
        done        = 1'b1;
        have_main   = 1'b0;
        wrap_scroll = 1'b0;
        main_res    = '0;
        state_next  = state;
        clamp_col   = '0;
        clamp_row   = '0;
        tab_col     = ({1'b0, state.col} | 9'd7) + 9'd1;

        scroll_res                  = '0;
        scroll_res.command          = CMD_MOVE;
        scroll_res.source_first_row = 8'd1;
        scroll_res.source_end_row   = last_row + 8'd1;
        scroll_res.dest_first_row   = 8'd0;
        scroll_res.blank_row        = last_row;

        case (state.phase)
            PH_ESC:
            begin
                state_next.phase = PH_TEXT;
                if (rx_byte == CH_BEL)
                begin
                    main_res.command = CMD_VBELL;
                    have_main        = 1'b1;
                end
                else if (rx_byte == CH_Y)
                begin
                    state_next.phase = PH_COL;
                    done             = 1'b0;
                end
                else if (rx_byte == CH_I)
                begin
                    main_res.command          = CMD_MOVE;
                    main_res.source_first_row = y;
                    main_res.source_end_row   = last_row;
                    main_res.dest_first_row   = y + 8'd1;
                    main_res.blank_row        = y;
                    have_main                 = 1'b1;
                end
                else if (rx_byte == CH_D)
                begin
                    main_res.command          = CMD_MOVE;
                    main_res.source_first_row = y + 8'd1;
                    main_res.source_end_row   = last_row + 8'd1;
                    main_res.dest_first_row   = y;
                    main_res.blank_row        = last_row;
                    have_main                 = 1'b1;
                end
                else if (rx_byte == CH_K)
                begin
                    main_res.command    = CMD_EOL;
                    main_res.target_col = x[7:0];
                    main_res.target_row = y;
                    have_main           = 1'b1;
                end
            end
            PH_COL:
            begin
                state_next.pending = rx_byte;
                state_next.phase   = PH_ROW;
                done               = 1'b0;
            end
            PH_ROW:
            begin
                clamp_col = (state.pending < CH_SP) ? 8'd0 : state.pending - CH_SP;
                if (clamp_col > last_column)
                    clamp_col = last_column;
                clamp_row = (rx_byte < CH_SP) ? 8'd0 : rx_byte - CH_SP;
                if (clamp_row > last_row)
                    clamp_row = last_row;
                x                = {1'b0, clamp_col};
                y                = clamp_row;
                state_next.phase = PH_TEXT;
            end
            default:
            begin
                case (rx_byte)
                    CH_BEL:
                    begin
                        main_res.command = CMD_BELL;
                        have_main        = 1'b1;
                    end
                    CH_UP:
                    begin
                        if (y > 8'd0)
                            y = y - 8'd1;
                    end
                    CH_TAB:
                        x = tab_col;
                    CH_ESC:
                    begin
                        state_next.phase = PH_ESC;
                        done             = 1'b0;
                    end
                    CH_BS:
                    begin
                        if (x > 9'd0)
                            x = x - 9'd1;
                    end
                    CH_LF:
                    begin
                        if (y >= last_row)
                        begin
                            main_res  = scroll_res;
                            have_main = 1'b1;
                            y         = last_row;
                        end
                        else
                            y = y + 8'd1;
                    end
                    CH_CR:
                        x = 9'd0;
                    CH_FF:
                    begin
                        main_res.command = CMD_CLEAR;
                        have_main        = 1'b1;
                        x                = 9'd0;
                        y                = 8'd0;
                    end
                    default:
                    begin
                        main_res.command    = CMD_DRAW;
                        main_res.glyph      = rx_byte;
                        main_res.target_col = x[7:0];
                        main_res.target_row = y;
                        have_main           = 1'b1;
                        x                   = x + 9'd1;
                    end
                endcase
            end
        endcase

        // automatic wrap past the last column
        if (done && (x > {1'b0, last_column}))
        begin
            x = 9'd0;
            if (y >= last_row)
            begin
                wrap_scroll = 1'b1;
                y           = last_row;
            end
            else
                y = y + 8'd1;
        end

        state_next.col = x[7:0];
        state_next.row = y;

        if (have_main)
            first = main_res;
        else if (wrap_scroll)
            first = scroll_res;
        else
            first = '0;
        second = scroll_res;
        two    = have_main && wrap_scroll;

        first.cursor_col  = x[7:0];
        first.cursor_row  = y;
        first.last        = !two;
        second.cursor_col = x[7:0];
        second.cursor_row = y;
        second.last       = 1'b1;
    end

endmodule

@@ rtl/ccterm_out_buf.sv @@
// two-entry result buffer feeding the output channel
module ccterm_out_buf
    import ccterm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t first,
    input  result_t second,
    input  logic    two,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    free,
    output result_t out_res
);

    logic    valid_reg;
    logic    has_second_reg;
    result_t res_reg;
    result_t res2_reg;

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign free      = !valid_reg || (out_ready && !has_second_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            has_second_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg      <= 1'b1;
            has_second_reg <= two;
        end
        else if (valid_reg && out_ready)
        begin
            if (has_second_reg)
                has_second_reg <= 1'b0;
            else
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= first;
            res2_reg <= second;
        end
        else if (valid_reg && out_ready && has_second_reg)
            res_reg <= res2_reg;
    end

    a_second_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        has_second_reg |-> valid_reg)
        else $error("second result pending without a valid first");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && has_second_reg) |-> !res_reg.last)
        else $error("first of two results marked last");

    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !has_second_reg) |-> res_reg.last)
        else $error("final result of a byte not marked last");

    a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && has_second_reg) |-> !load)
        else $error("load over a pending second result");

endmodule

@@ rtl/char_cell_terminal_controller.sv @@
// top level of the character-cell terminal controller
// usage:
//   rx_valid/rx_ready carry one received byte per transfer on rx_byte.
//   tx_valid/tx_ready carry one display command per transfer; a byte yields
//   one command, or two when a drawn character wraps past the bottom row or
//   a line feed at the bottom also wraps the column; last marks the final one.
//   cfg_write with cfg_index and cfg_data sets last_column (index 0) or
//   last_row (index 1) through a register; values above 254 saturate to 254.
// path: a taken byte is held in the input register, decoded, then loaded into
//   the result buffer once it is free, and shown on the output from there.
// throughput: one byte per cycle while tx_ready is high and each byte yields
//   a single command; a two-command byte holds the buffer until both are sent.
// reset: cursor at column 0 row 0, parser in text mode, screen 80 x 72.
// stall: while tx_ready is low the result buffer holds, the input register
//   keeps one further byte and rx_ready drops until the buffer frees.
module char_cell_terminal_controller
    import ccterm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       tx_valid,
    input  logic       tx_ready,
    output logic [2:0] command,
    output logic [7:0] glyph,
    output logic [7:0] target_col,
    output logic [7:0] target_row,
    output logic [7:0] source_first_row,
    output logic [7:0] source_end_row,
    output logic [7:0] dest_first_row,
    output logic [7:0] blank_row,
    output logic [7:0] cursor_col,
    output logic [7:0] cursor_row,
    output logic       last
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [7:0]  last_column_reg;
    logic [7:0]  last_row_reg;
    logic [7:0]  cfg_sat;
    term_state_t state_reg;
    term_state_t state_next;
    result_t     first;
    result_t     second;
    result_t     out_res;
    logic        two;
    logic        free;
    logic        load;

    assign load     = in_valid_reg && free;
    assign rx_ready = !in_valid_reg || load;
    assign cfg_sat  = (cfg_data > REG_MAX) ? REG_MAX : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            state_reg       <= '0;
            last_column_reg <= 8'd79;
            last_row_reg    <= 8'd71;
        end
        else
        begin
            if (rx_valid && rx_ready)
                in_valid_reg <= 1'b1;
            else if (load)
                in_valid_reg <= 1'b0;
            if (load)
                state_reg <= state_next;
            if (cfg_write && (cfg_index == REG_LAST_COLUMN))
                last_column_reg <= cfg_sat;
            if (cfg_write && (cfg_index == REG_LAST_ROW))
                last_row_reg <= cfg_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
            in_byte_reg <= rx_byte;
    end

    ccterm_decode u_decode (
        .rx_byte     (in_byte_reg),
        .state       (state_reg),
        .last_column (last_column_reg),
        .last_row    (last_row_reg),
        .state_next  (state_next),
        .first       (first),
        .second      (second),
        .two         (two)
    );

    ccterm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .first     (first),
        .second    (second),
        .two       (two),
        .out_ready (tx_ready),
        .out_valid (tx_valid),
        .free      (free),
        .out_res   (out_res)
    );

    assign command          = out_res.command;
    assign glyph            = out_res.glyph;
    assign target_col       = out_res.target_col;
    assign target_row       = out_res.target_row;
    assign source_first_row = out_res.source_first_row;
    assign source_end_row   = out_res.source_end_row;
    assign dest_first_row   = out_res.dest_first_row;
    assign blank_row        = out_res.blank_row;
    assign cursor_col       = out_res.cursor_col;
    assign cursor_row       = out_res.cursor_row;
    assign last             = out_res.last;

    a_cfg_range: assert property (@(posedge clk) disable iff (!rst_n)
        (last_column_reg <= REG_MAX) && (last_row_reg <= REG_MAX))
        else $error("screen limit register above maximum");

    a_state_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(load) |-> $stable(state_reg))
        else $error("cursor state changed without a byte transfer");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> tx_valid)
        else $error("decoded byte did not reach the output");

endmodule
